// ===== sv/battery_power_supervisor_macros.svh =====
// Assertion macros shared by the supervisor RTL.
`ifndef BATTERY_POWER_SUPERVISOR_MACROS_SVH
`define BATTERY_POWER_SUPERVISOR_MACROS_SVH

// check cons in the same cycle whenever ante holds
`define BPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante holds
`define BPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bps_pkg.sv =====
// Types and codes of the battery power supervisor.
package bps_pkg;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_MODE = 1'b1;

	localparam logic [1:0] MODE_STOP        = 2'd0;
	localparam logic [1:0] MODE_SMOOTH_STOP = 2'd1;
	localparam logic [1:0] MODE_RUN         = 2'd2;

	localparam int unsigned ADDR_W = 5;

	localparam logic [2:0] REG_LOW_MV        = 3'd0;
	localparam logic [2:0] REG_CRIT_MV       = 3'd1;
	localparam logic [2:0] REG_WARN_REPEAT   = 3'd2;
	localparam logic [2:0] REG_SHUTDOWN_DLY  = 3'd3;
	localparam logic [2:0] REG_SHUTDOWN_SND  = 3'd4;
	localparam logic [2:0] REG_STAGE_OFF_DLY = 3'd5;

	typedef struct packed {
		logic        command;
		logic [15:0] battery_mv;
		logic [1:0]  mode;
	} bps_sample_t;

	typedef struct packed {
		logic battery_low;
		logic battery_critical;
		logic warning_sound;
		logic power_off_sound;
		logic main_power_off;
		logic stage_enable;
		logic stage_on;
		logic relay_restart;
	} bps_result_t;

endpackage

// ===== sv/bps_sample_if.sv =====
// Input channel carrying monitor ticks and mode commands.
interface bps_sample_if;
	import bps_pkg::*;

	logic        valid;
	logic        ready;
	bps_sample_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/bps_result_if.sv =====
// Output channel carrying one status result per transaction.
interface bps_result_if;
	import bps_pkg::*;

	logic        valid;
	logic        ready;
	bps_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/battery_power_supervisor.sv =====
// Battery power supervisor: threshold monitor, warning and shutdown timers, stage control.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------------
//  sample   | in  | valid / ready | command, battery_mv, mode
//  result   | out | valid / ready | low, critical, sounds, power off, stage flags
//  apb      | in  | psel/penable  | six threshold and period registers
//
// One transaction per cycle while the result is not stalled; each sample passes through
// the input register and then the result register, which each hold one transaction; state
// updates when a transaction moves from the input register into the result register.
// A stall holds the result register and a full input register; sample ready drops only
// when both are full. arst_n clears state, config registers and valid flags at once.
`include "battery_power_supervisor_macros.svh"

module battery_power_supervisor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bps_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	bps_sample_if.sink                   sample,
	bps_result_if.source                 result
);
	import bps_pkg::*;

	logic [15:0] low_mv_q, crit_mv_q;
	logic [31:0] warn_rep_q, sd_delay_q, sd_sound_q, so_delay_q;

	logic [1:0]  cur_mode_q;
	logic [31:0] warn_cnt_q, sd_cnt_q, so_cnt_q;
	logic        low_q, crit_q, latch_q, enable_q, on_q;

	logic        valid_s1;
	bps_sample_t sample_s1;
	logic        valid_s2;
	bps_result_t res_s2;

	logic        advance;
	logic        step;
	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	logic        low_t, crit_t;
	logic [31:0] warn_base, warn_dec, warn_nxt;
	logic [31:0] sd_base, sd_dec, sd_nxt;
	logic [31:0] so_dec, so_nxt;
	logic [1:0]  mode_nxt;
	logic        low_nxt, crit_nxt, latch_nxt, enable_nxt, on_nxt;
	logic        warn_snd, off_snd, restart;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_mv_q   <= '0;
			crit_mv_q  <= '0;
			warn_rep_q <= '0;
			sd_delay_q <= '0;
			sd_sound_q <= '0;
			so_delay_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_LOW_MV:        low_mv_q   <= pwdata[15:0];
				REG_CRIT_MV:       crit_mv_q  <= pwdata[15:0];
				REG_WARN_REPEAT:   warn_rep_q <= pwdata;
				REG_SHUTDOWN_DLY:  sd_delay_q <= pwdata;
				REG_SHUTDOWN_SND:  sd_sound_q <= pwdata;
				REG_STAGE_OFF_DLY: so_delay_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_LOW_MV:        prdata = {16'd0, low_mv_q};
			REG_CRIT_MV:       prdata = {16'd0, crit_mv_q};
			REG_WARN_REPEAT:   prdata = warn_rep_q;
			REG_SHUTDOWN_DLY:  prdata = sd_delay_q;
			REG_SHUTDOWN_SND:  prdata = sd_sound_q;
			REG_STAGE_OFF_DLY: prdata = so_delay_q;
			default:           prdata = '0;
		endcase
	end

	assign advance      = !valid_s2 || result.ready;
	assign step         = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			sample_s1 <= sample.data;
		end
	end

	always_comb begin
		low_t      = sample_s1.battery_mv < low_mv_q;
		crit_t     = sample_s1.battery_mv < crit_mv_q;
		mode_nxt   = cur_mode_q;
		low_nxt    = low_q;
		crit_nxt   = crit_q;
		latch_nxt  = latch_q;
		enable_nxt = enable_q;
		on_nxt     = on_q;
		warn_nxt   = warn_cnt_q;
		sd_nxt     = sd_cnt_q;
		so_nxt     = so_cnt_q;
		warn_snd   = 1'b0;
		off_snd    = 1'b0;
		restart    = 1'b0;

		if (low_t && !crit_t) begin
			warn_base = (warn_cnt_q == '0) ? warn_rep_q : warn_cnt_q;
		end else begin
			warn_base = '0;
		end
		warn_dec = warn_base - 32'd1;

		if (crit_t) begin
			sd_base = (sd_cnt_q == '0) ? sd_delay_q : sd_cnt_q;
		end else begin
			sd_base = '0;
		end
		sd_dec = sd_base - 32'd1;
		so_dec = so_cnt_q - 32'd1;

		if (sample_s1.command == CMD_TICK) begin
			low_nxt  = low_t;
			crit_nxt = crit_t;
			warn_nxt = warn_base;
			if (warn_base != '0) begin
				if (warn_dec == '0) begin
					warn_snd = 1'b1;
					warn_nxt = warn_rep_q;
				end else begin
					warn_nxt = warn_dec;
				end
			end
			sd_nxt = sd_base;
			if (sd_base != '0) begin
				sd_nxt = sd_dec;
				if (sd_dec == '0) begin
					latch_nxt = 1'b1;
				end
			end
			off_snd = (sd_nxt == sd_sound_q);
			if (so_cnt_q != '0) begin
				so_nxt = so_dec;
				if (so_dec == '0) begin
					enable_nxt = 1'b0;
				end
			end
		end else if (sample_s1.mode != cur_mode_q) begin
			mode_nxt = sample_s1.mode;
			case (sample_s1.mode)
				MODE_STOP:        enable_nxt = 1'b0;
				MODE_SMOOTH_STOP: so_nxt = so_delay_q;
				default: begin
					enable_nxt = 1'b1;
					on_nxt     = 1'b1;
					restart    = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode_q <= MODE_STOP;
			warn_cnt_q <= '0;
			sd_cnt_q   <= '0;
			so_cnt_q   <= '0;
			low_q      <= 1'b0;
			crit_q     <= 1'b0;
			latch_q    <= 1'b0;
			enable_q   <= 1'b0;
			on_q       <= 1'b0;
		end else if (step) begin
			cur_mode_q <= mode_nxt;
			warn_cnt_q <= warn_nxt;
			sd_cnt_q   <= sd_nxt;
			so_cnt_q   <= so_nxt;
			low_q      <= low_nxt;
			crit_q     <= crit_nxt;
			latch_q    <= latch_nxt;
			enable_q   <= enable_nxt;
			on_q       <= on_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2.battery_low      <= low_nxt;
			res_s2.battery_critical <= crit_nxt;
			res_s2.warning_sound    <= warn_snd;
			res_s2.power_off_sound  <= off_snd;
			res_s2.main_power_off   <= latch_nxt;
			res_s2.stage_enable     <= enable_nxt;
			res_s2.stage_on         <= on_nxt;
			res_s2.relay_restart    <= restart;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

	`BPS_ASSERT_NEXT(a_latch_holds, latch_q, latch_q, "main power off latch dropped")
	`BPS_ASSERT_NEXT(a_mode_no_sound, step && sample_s1.command == CMD_MODE,
		!res_s2.warning_sound && !res_s2.power_off_sound, "sound pulse on mode command")
	`BPS_ASSERT_NOW(a_restart_on, valid_s2 && res_s2.relay_restart,
		res_s2.stage_enable && res_s2.stage_on, "relay restart without stage on")
	`BPS_ASSERT_NOW(a_crit_no_warn, warn_cnt_q != '0, low_q && !crit_q,
		"warning counter running outside low battery")

endmodule

// ===== test/battery_power_supervisor_test.sv =====
// Self-checking testbench for the battery power supervisor: stream and register traffic.
`timescale 1ns / 1ps

module battery_power_supervisor_test;
	import bps_pkg::*;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	logic                smp_valid = 1'b0;
	bps_sample_t         smp_data = '0;
	logic                res_ready = 1'b0;
	logic                smp_taken = 1'b0;
	logic                res_taken = 1'b0;

	bps_sample_if s_if ();
	bps_result_if r_if ();

	assign s_if.valid = smp_valid;
	assign s_if.data  = smp_data;
	assign r_if.ready = res_ready;

	battery_power_supervisor u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sample  (s_if),
		.result  (r_if)
	);

	// predictor copy of the registers and state
	logic [15:0] cfg_low_mv = '0;
	logic [15:0] cfg_crit_mv = '0;
	logic [31:0] cfg_warn_period = '0;
	logic [31:0] cfg_shut_delay = '0;
	logic [31:0] cfg_shut_sound = '0;
	logic [31:0] cfg_stage_delay = '0;

	logic [1:0]  mode_q = MODE_STOP;
	logic [31:0] warn_cnt = '0;
	logic [31:0] shut_cnt = '0;
	logic [31:0] stage_cnt = '0;
	logic        low_q = 1'b0;
	logic        crit_q = 1'b0;
	logic        latch_q = 1'b0;
	logic        enable_q = 1'b0;
	logic        on_q = 1'b0;

	bps_sample_t queued_items [$];
	bps_result_t status_expected [$];
	int unsigned mismatches = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	int unsigned hold_left = 0;
	int unsigned hold_req = 0;
	int unsigned hold_done = 0;
	bit          no_idle = 1'b0;

	string field_name [8] = '{"relay_restart", "stage_on", "stage_enable", "main_power_off",
		"power_off_sound", "warning_sound", "battery_critical", "battery_low"};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("battery_power_supervisor regression: fail");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		if (mismatches < 100)
			$display("%0t ns mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic bps_result_t next_status(input bps_sample_t s);
		bps_result_t r;
		logic warn_pulse;
		logic off_pulse;
		logic restart;
		warn_pulse = 1'b0;
		off_pulse = 1'b0;
		restart = 1'b0;
		if (s.command == CMD_TICK) begin
			low_q = s.battery_mv < cfg_low_mv;
			crit_q = s.battery_mv < cfg_crit_mv;
			if (low_q && !crit_q) begin
				if (warn_cnt == 0)
					warn_cnt = cfg_warn_period;
			end else begin
				warn_cnt = '0;
			end
			if (crit_q) begin
				if (shut_cnt == 0)
					shut_cnt = cfg_shut_delay;
			end else begin
				shut_cnt = '0;
			end
			if (warn_cnt != 0) begin
				warn_cnt = warn_cnt - 1;
				if (warn_cnt == 0) begin
					warn_pulse = 1'b1;
					warn_cnt = cfg_warn_period;
				end
			end
			if (shut_cnt != 0) begin
				shut_cnt = shut_cnt - 1;
				if (shut_cnt == 0)
					latch_q = 1'b1;
			end
			off_pulse = (shut_cnt == cfg_shut_sound);
			if (stage_cnt != 0) begin
				stage_cnt = stage_cnt - 1;
				if (stage_cnt == 0)
					enable_q = 1'b0;
			end
		end else if (s.mode != mode_q) begin
			mode_q = s.mode;
			if (s.mode == MODE_STOP) begin
				enable_q = 1'b0;
			end else if (s.mode == MODE_SMOOTH_STOP) begin
				stage_cnt = cfg_stage_delay;
			end else begin
				enable_q = 1'b1;
				on_q = 1'b1;
				restart = 1'b1;
			end
		end
		r.battery_low = low_q;
		r.battery_critical = crit_q;
		r.warning_sound = warn_pulse;
		r.power_off_sound = off_pulse;
		r.main_power_off = latch_q;
		r.stage_enable = enable_q;
		r.stage_on = on_q;
		r.relay_restart = restart;
		return r;
	endfunction

	always @(posedge clk) begin : monitor
		bps_result_t got;
		bps_result_t want;
		smp_taken <= arst_n && smp_valid && s_if.ready;
		res_taken <= arst_n && r_if.valid && res_ready;
		if (arst_n && r_if.valid && res_ready) begin
			got = r_if.data;
			if (status_expected.size() == 0) begin
				flag_mismatch("result with nothing expected");
			end else begin
				want = status_expected.pop_front();
				for (int i = 0; i < 8; i++)
					if (got[i] !== want[i])
						flag_mismatch($sformatf("%s got %b want %b", field_name[i],
							got[i], want[i]));
			end
		end
		if (arst_n && smp_valid && s_if.ready)
			status_expected.push_back(next_status(smp_data));
	end

	always @(negedge clk) begin : driver
		if (arst_n && (!smp_valid || smp_taken)) begin
			if (send_gap > 0) begin
				smp_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (queued_items.size() > 0) begin
				smp_valid <= 1'b1;
				smp_data <= queued_items.pop_front();
				send_gap <= draw_gap();
			end else begin
				smp_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		int unsigned g;
		if (arst_n) begin
			if (hold_left > 0) begin
				res_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_req != hold_done) begin
				res_ready <= 1'b0;
				hold_left <= 300;
				hold_done <= hold_done + 1;
			end else if (recv_gap > 0) begin
				res_ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				g = res_taken ? draw_gap() : 0;
				res_ready <= (g == 0);
				recv_gap <= (g == 0) ? 0 : g - 1;
			end
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LOW_MV:        cfg_low_mv = val[15:0];
			REG_CRIT_MV:       cfg_crit_mv = val[15:0];
			REG_WARN_REPEAT:   cfg_warn_period = val;
			REG_SHUTDOWN_DLY:  cfg_shut_delay = val;
			REG_SHUTDOWN_SND:  cfg_shut_sound = val;
			REG_STAGE_OFF_DLY: cfg_stage_delay = val;
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [15:0] low_mv, input logic [15:0] crit_mv,
		input logic [31:0] warn, input logic [31:0] shut, input logic [31:0] snd,
		input logic [31:0] stage);
		apb_write(REG_LOW_MV, {16'($urandom()), low_mv});
		apb_write(REG_CRIT_MV, {16'($urandom()), crit_mv});
		apb_write(REG_WARN_REPEAT, warn);
		apb_write(REG_SHUTDOWN_DLY, shut);
		apb_write(REG_SHUTDOWN_SND, snd);
		apb_write(REG_STAGE_OFF_DLY, stage);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (queued_items.size() != 0 || smp_valid || status_expected.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic add_tick(input logic [15:0] mv);
		bps_sample_t s;
		s.command = CMD_TICK;
		s.battery_mv = mv;
		s.mode = 2'($urandom_range(0, 3));
		queued_items.push_back(s);
	endtask

	task automatic add_mode(input logic [1:0] m);
		bps_sample_t s;
		s.command = CMD_MODE;
		s.battery_mv = 16'($urandom());
		s.mode = m;
		queued_items.push_back(s);
	endtask

	// 0 below critical, 1 low but not critical, 2 above both
	function automatic logic [15:0] band_value(input int unsigned band);
		int lo;
		int hi;
		case (band)
			0: begin
				lo = 0;
				hi = int'(cfg_crit_mv) - 1;
			end
			1: begin
				lo = int'(cfg_crit_mv);
				hi = int'(cfg_low_mv) - 1;
			end
			default: begin
				lo = (cfg_low_mv > cfg_crit_mv) ? int'(cfg_low_mv) : int'(cfg_crit_mv);
				hi = 65535;
			end
		endcase
		if (hi < lo)
			return 16'($urandom());
		case ($urandom_range(0, 7))
			0: return 16'(lo);
			1: return 16'(hi);
			default: return 16'($urandom_range(lo, hi));
		endcase
	endfunction

	task automatic queue_traffic(input int unsigned n);
		int unsigned left;
		int unsigned run;
		int unsigned band;
		int unsigned r;
		left = n;
		while (left > 0) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				add_mode(2'($urandom_range(0, 3)));
				left--;
			end else if (r < 18) begin
				add_tick(16'($urandom()));
				left--;
			end else begin
				run = $urandom_range(1, 40);
				if (run > left)
					run = left;
				band = $urandom_range(0, 2);
				repeat (run) add_tick(band_value(band));
				left -= run;
			end
		end
	endtask

	task automatic random_setting(input int unsigned shut_lo, input int unsigned shut_hi);
		logic [15:0] low_mv;
		logic [15:0] crit_mv;
		logic [31:0] shut;
		low_mv = 16'($urandom_range(2000, 20000));
		crit_mv = 16'($urandom_range(500, low_mv));
		shut = $urandom_range(shut_lo, shut_hi);
		write_all(low_mv, crit_mv, $urandom_range(1, 8), shut, $urandom_range(0, shut),
			$urandom_range(1, 10));
	endtask

	initial begin : sequencer
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: zero thresholds, zero delays, sound point zero
		add_tick(16'h0000);
		add_tick(16'hFFFF);
		add_mode(MODE_STOP);
		add_mode(MODE_RUN);
		add_mode(MODE_RUN);
		add_mode(2'd3);
		add_mode(MODE_SMOOTH_STOP);
		add_tick(16'h5555);
		add_mode(MODE_STOP);
		wait_drained();

		write_all(16'd10000, 16'd7000, 32'd3, 32'd5, 32'd2, 32'd2);
		add_mode(MODE_RUN);
		add_mode(MODE_SMOOTH_STOP);
		repeat (4) add_tick(16'd9000);
		repeat (3) add_tick(16'd6999);
		add_tick(16'd7000);
		add_tick(16'd10000);
		add_mode(MODE_RUN);
		add_mode(MODE_SMOOTH_STOP);
		add_mode(MODE_RUN);
		repeat (2) add_tick(16'd12000);
		add_mode(MODE_STOP);
		wait_drained();

		// long receiver hold-off while the sender keeps offering
		random_setting(41, 80);
		hold_req = hold_req + 1;
		queue_traffic(260);
		wait_drained();

		no_idle = 1'b1;
		write_all(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		queue_traffic(260);
		wait_drained();
		no_idle = 1'b0;

		write_all(16'($urandom_range(1000, 20000)), 16'($urandom_range(0, 10000)), '0, '0,
			'0, '0);
		queue_traffic(260);
		wait_drained();

		// critical threshold above the low one
		random_setting(41, 80);
		apb_write(REG_CRIT_MV, 32'(cfg_low_mv) + $urandom_range(1, 3000));
		queue_traffic(260);
		wait_drained();

		random_setting(1, 8);
		queue_traffic(260);
		wait_drained();

		if (mismatches == 0)
			$display("battery_power_supervisor regression: pass");
		else
			$display("battery_power_supervisor regression: fail");
		$finish;
	end

endmodule
